// ----- rtl/core/aabb_rq_pkg.sv -----
// Shared types, constants and codes for the region overlap query block.
// Used by every module in rtl/core except aabb_rq_ram; depends on nothing else.
package aabb_rq_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_MATCHES_DEF = 8;

    localparam int CFG_W   = 7;
    localparam int COORD_W = 32;
    localparam int IDX_W   = 6;
    localparam int RN_W    = 6;
    localparam int BOUND_W = 33;
    localparam int MID_W   = 34;
    localparam int DIFF_W  = 35;
    localparam int MAG_W   = 34;
    localparam int HALF_W  = 17;
    localparam int PART_W  = MAG_W + HALF_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int DIST_W  = SQ_W + 1;

    localparam int DRAIN_CYC = 5;
    localparam int DRAIN_W   = 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        MODE_3D,
        MODE_XZ,
        MODE_NEAR,
        MODE_NONE
    } t_mode;

    typedef struct packed {
        logic                       cmd;
        logic [IDX_W-1:0]           entry_index;
        logic                       entry_valid;
        logic signed [COORD_W-1:0]  corner_a_x;
        logic signed [COORD_W-1:0]  corner_a_y;
        logic signed [COORD_W-1:0]  corner_a_z;
        logic signed [COORD_W-1:0]  corner_b_x;
        logic signed [COORD_W-1:0]  corner_b_y;
        logic signed [COORD_W-1:0]  corner_b_z;
        logic signed [COORD_W-1:0]  pad_x;
        logic signed [COORD_W-1:0]  pad_y;
        logic signed [COORD_W-1:0]  pad_z;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [RN_W-1:0]   region_number;
        logic              last_of_answer;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    localparam int BOX_W = $bits(t_box);

    typedef struct packed {
        logic  wr_entry;
        logic  cap_query;
        logic  rd_en;
        logic  emit;
        logic  last;
        t_mode mode;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic have_best;
    } t_dp_stat;

endpackage

// ----- rtl/core/aabb_rq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module aabb_rq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/aabb_rq_dp.sv -----
// Datapath: region table, query box, overlap tests, distance pipeline,
// match lists and result register. Depends on aabb_rq_pkg and aabb_rq_ram.
module aabb_rq_dp #(
    parameter int TABLE_DEPTH = aabb_rq_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_MATCHES = aabb_rq_pkg::MAX_MATCHES_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  aabb_rq_pkg::t_in                            i_in,
    input  aabb_rq_pkg::t_dp_cmd                        i_cmd,
    input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_MATCHES + 1)-1:0]          i_emit_k,
    input  logic                                        i_out_stall,
    output aabb_rq_pkg::t_dp_stat                       o_stat,
    output logic [$clog2(MAX_MATCHES + 1)-1:0]          o_cnt3,
    output logic [$clog2(MAX_MATCHES + 1)-1:0]          o_cntxz,
    output logic                                        o_out_valid,
    output aabb_rq_pkg::t_out                           o_out
);

    localparam int AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = AW > aabb_rq_pkg::RN_W ? AW : aabb_rq_pkg::RN_W;
    localparam int KW = $clog2(MAX_MATCHES + 1);
    localparam int LW = MAX_MATCHES > 1 ? $clog2(MAX_MATCHES) : 1;
    localparam int BW = aabb_rq_pkg::BOUND_W;
    localparam int HW = aabb_rq_pkg::HALF_W;
    localparam int MW = aabb_rq_pkg::MAG_W;

    function automatic logic signed [BW-1:0] pad_mag(input logic signed [31:0] p);
        logic signed [BW-1:0] w;
        w = BW'(p);
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic signed [BW-1:0] lo_bound(input logic signed [31:0] a,
            input logic signed [31:0] b, input logic signed [31:0] p);
        logic signed [BW-1:0] m;
        m = (a < b) ? BW'(a) : BW'(b);
        return m - pad_mag(p);
    endfunction

    function automatic logic signed [BW-1:0] hi_bound(input logic signed [31:0] a,
            input logic signed [31:0] b, input logic signed [31:0] p);
        logic signed [BW-1:0] m;
        m = (a > b) ? BW'(a) : BW'(b);
        return m + pad_mag(p);
    endfunction

    function automatic logic [MW-1:0] axis_mag(input logic signed [aabb_rq_pkg::MID_W-1:0] mq,
            input logic signed [31:0] lo, input logic signed [31:0] hi);
        logic signed [aabb_rq_pkg::DIFF_W-1:0] d;
        d = aabb_rq_pkg::DIFF_W'(mq) - (aabb_rq_pkg::DIFF_W'(lo) + aabb_rq_pkg::DIFF_W'(hi));
        return (d < 0) ? MW'(-d) : MW'(d);
    endfunction

    // Table storage and valid flags.
    logic                     r_vbits [TABLE_DEPTH];
    logic [EW-1:0]            wr_ext;
    logic [AW-1:0]            wr_addr;
    logic                     wr_ok;
    aabb_rq_pkg::t_box        wr_box;
    aabb_rq_pkg::t_box        rd_box;
    logic [aabb_rq_pkg::BOX_W-1:0] rd_bits;

    assign wr_ext  = EW'(i_in.entry_index);
    assign wr_addr = wr_ext[AW-1:0];
    assign wr_ok   = i_cmd.wr_entry && (32'(i_in.entry_index) < TABLE_DEPTH);
    assign wr_box  = '{min_x: i_in.corner_a_x, min_y: i_in.corner_a_y,
                       min_z: i_in.corner_a_z, max_x: i_in.corner_b_x,
                       max_y: i_in.corner_b_y, max_z: i_in.corner_b_z};

    aabb_rq_ram #(
        .WIDTH (aabb_rq_pkg::BOX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (wr_addr),
        .i_wdata (wr_box),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_bits)
    );

    assign rd_box = aabb_rq_pkg::t_box'(rd_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_vbits[i] <= 1'b0;
            end
        end else if (wr_ok) begin
            r_vbits[wr_addr] <= i_in.entry_valid;
        end
    end

    // Query box, held for the whole scan.
    logic signed [BW-1:0] r_qn_x, r_qx_x, r_qn_y, r_qx_y, r_qn_z, r_qx_z;
    logic signed [aabb_rq_pkg::MID_W-1:0] r_mq_x, r_mq_z;
    logic signed [BW-1:0] n_qn_x, n_qx_x, n_qn_z, n_qx_z;

    assign n_qn_x = lo_bound(i_in.corner_a_x, i_in.corner_b_x, i_in.pad_x);
    assign n_qx_x = hi_bound(i_in.corner_a_x, i_in.corner_b_x, i_in.pad_x);
    assign n_qn_z = lo_bound(i_in.corner_a_z, i_in.corner_b_z, i_in.pad_z);
    assign n_qx_z = hi_bound(i_in.corner_a_z, i_in.corner_b_z, i_in.pad_z);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_query) begin
            r_qn_x <= n_qn_x;
            r_qx_x <= n_qx_x;
            r_qn_y <= lo_bound(i_in.corner_a_y, i_in.corner_b_y, i_in.pad_y);
            r_qx_y <= hi_bound(i_in.corner_a_y, i_in.corner_b_y, i_in.pad_y);
            r_qn_z <= n_qn_z;
            r_qx_z <= n_qx_z;
            r_mq_x <= aabb_rq_pkg::MID_W'(n_qn_x) + aabb_rq_pkg::MID_W'(n_qx_x);
            r_mq_z <= aabb_rq_pkg::MID_W'(n_qn_z) + aabb_rq_pkg::MID_W'(n_qx_z);
        end
    end

    // Scan pipeline control.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [AW-1:0] r_i1, r_i2, r_i3, r_i4, r_i5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en && r_vbits[i_rd_addr];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= i_rd_addr;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
        r_i5 <= r_i4;
    end

    // Overlap tests on the entry just read.
    logic ov_xz, ov_3d;

    assign ov_xz = (r_qx_x >= BW'(rd_box.min_x)) && (r_qn_x <= BW'(rd_box.max_x)) &&
                   (r_qx_z >= BW'(rd_box.min_z)) && (r_qn_z <= BW'(rd_box.max_z));
    assign ov_3d = ov_xz && (r_qx_y >= BW'(rd_box.min_y)) && (r_qn_y <= BW'(rd_box.max_y));

    logic [AW-1:0] r_list3  [MAX_MATCHES];
    logic [AW-1:0] r_listxz [MAX_MATCHES];
    logic [KW-1:0] r_c3, r_cxz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cap_query) begin
            r_c3  <= '0;
            r_cxz <= '0;
        end else if (r_v1) begin
            if (ov_3d && (32'(r_c3) < MAX_MATCHES)) begin
                r_c3 <= r_c3 + KW'(1);
            end
            if (ov_xz && (32'(r_cxz) < MAX_MATCHES)) begin
                r_cxz <= r_cxz + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && ov_3d && (32'(r_c3) < MAX_MATCHES)) begin
            r_list3[r_c3[LW-1:0]] <= r_i1;
        end
        if (r_v1 && ov_xz && (32'(r_cxz) < MAX_MATCHES)) begin
            r_listxz[r_cxz[LW-1:0]] <= r_i1;
        end
    end

    // Squared X-Z midpoint distance, at most one multiplier per axis per stage.
    logic [MW-1:0]                    r_dx, r_dz, r_dx3, r_dz3;
    logic [aabb_rq_pkg::PART_W-1:0]   r_plx, r_plz;
    logic [aabb_rq_pkg::SQ_W-1:0]     r_sqx, r_sqz;
    logic [aabb_rq_pkg::DIST_W-1:0]   r_d, r_best;
    logic [AW-1:0]                    r_best_i;
    logic                             r_have;

    always_ff @(posedge i_clk) begin
        r_dx  <= axis_mag(r_mq_x, rd_box.min_x, rd_box.max_x);
        r_dz  <= axis_mag(r_mq_z, rd_box.min_z, rd_box.max_z);
        r_plx <= r_dx * r_dx[HW-1:0];
        r_plz <= r_dz * r_dz[HW-1:0];
        r_dx3 <= r_dx;
        r_dz3 <= r_dz;
        r_sqx <= aabb_rq_pkg::SQ_W'(r_plx) +
                 (aabb_rq_pkg::SQ_W'(r_dx3 * r_dx3[MW-1:HW]) << HW);
        r_sqz <= aabb_rq_pkg::SQ_W'(r_plz) +
                 (aabb_rq_pkg::SQ_W'(r_dz3 * r_dz3[MW-1:HW]) << HW);
        r_d   <= aabb_rq_pkg::DIST_W'(r_sqx) + aabb_rq_pkg::DIST_W'(r_sqz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cap_query) begin
            r_have <= 1'b0;
        end else if (r_v5 && (!r_have || (r_d < r_best))) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v5 && (!r_have || (r_d < r_best))) begin
            r_best   <= r_d;
            r_best_i <= r_i5;
        end
    end

    // Result register.
    logic               r_out_valid;
    aabb_rq_pkg::t_out  r_out;
    logic [AW-1:0]      sel_idx;
    logic [EW-1:0]      sel_ext;

    always_comb begin
        case (i_cmd.mode)
            aabb_rq_pkg::MODE_3D:   sel_idx = r_list3[i_emit_k[LW-1:0]];
            aabb_rq_pkg::MODE_XZ:   sel_idx = r_listxz[i_emit_k[LW-1:0]];
            aabb_rq_pkg::MODE_NEAR: sel_idx = r_best_i;
            default:                sel_idx = '0;
        endcase
    end

    assign sel_ext = EW'(sel_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.found          <= (i_cmd.mode != aabb_rq_pkg::MODE_NONE);
            r_out.region_number  <= sel_ext[aabb_rq_pkg::RN_W-1:0];
            r_out.last_of_answer <= i_cmd.last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out            = r_out;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.have_best = r_have;
    assign o_cnt3           = r_c3;
    assign o_cntxz          = r_cxz;

endmodule

// ----- rtl/core/aabb_rq_ctrl.sv -----
// Controller: request handshake, scan counter, drain wait and result sequencing.
// Also holds the scan-count register. Depends on aabb_rq_pkg.
module aabb_rq_ctrl #(
    parameter int TABLE_DEPTH = aabb_rq_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_MATCHES = aabb_rq_pkg::MAX_MATCHES_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    input  logic                                        i_in_cmd,
    output logic                                        o_in_stall,
    input  logic                                        i_cfg_valid,
    input  logic [aabb_rq_pkg::CFG_W-1:0]               i_cfg_data,
    output logic                                        o_cfg_ready,
    input  aabb_rq_pkg::t_dp_stat                       i_stat,
    input  logic [$clog2(MAX_MATCHES + 1)-1:0]          i_cnt3,
    input  logic [$clog2(MAX_MATCHES + 1)-1:0]          i_cntxz,
    output aabb_rq_pkg::t_dp_cmd                        o_cmd,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] o_rd_addr,
    output logic [$clog2(MAX_MATCHES + 1)-1:0]          o_emit_k
);

    localparam int AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = $clog2(MAX_MATCHES + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [aabb_rq_pkg::CFG_W-1:0] r_active;
    logic [SW-1:0]                r_scan, n_scan, scan_n;
    logic [aabb_rq_pkg::DRAIN_W-1:0] r_drain, n_drain;
    logic [KW-1:0]                r_k, n_k, r_cnt, n_cnt;
    aabb_rq_pkg::t_mode           r_mode, n_mode;
    logic                         accept, is_last;

    assign scan_n = (32'(r_active) > TABLE_DEPTH) ? SW'(TABLE_DEPTH) : SW'(r_active);
    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign is_last = (r_k == r_cnt - KW'(1));

    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        n_drain = r_drain;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_mode  = r_mode;
        o_cmd.wr_entry  = accept && (i_in_cmd == aabb_rq_pkg::CMD_LOAD);
        o_cmd.cap_query = accept && (i_in_cmd == aabb_rq_pkg::CMD_QUERY);
        o_cmd.rd_en     = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.last      = is_last;
        o_cmd.mode      = r_mode;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.cap_query) begin
                    n_state = ST_SCAN;
                    n_scan  = '0;
                end
            end
            ST_SCAN: begin
                if (r_scan == scan_n) begin
                    n_state = ST_DRAIN;
                    n_drain = '0;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_scan      = r_scan + SW'(1);
                end
            end
            ST_DRAIN: begin
                if (r_drain == aabb_rq_pkg::DRAIN_W'(aabb_rq_pkg::DRAIN_CYC - 1)) begin
                    n_state = ST_EMIT;
                    n_k     = '0;
                    if (i_cnt3 != '0) begin
                        n_mode = aabb_rq_pkg::MODE_3D;
                        n_cnt  = i_cnt3;
                    end else if (i_cntxz != '0) begin
                        n_mode = aabb_rq_pkg::MODE_XZ;
                        n_cnt  = i_cntxz;
                    end else if (i_stat.have_best) begin
                        n_mode = aabb_rq_pkg::MODE_NEAR;
                        n_cnt  = KW'(1);
                    end else begin
                        n_mode = aabb_rq_pkg::MODE_NONE;
                        n_cnt  = KW'(1);
                    end
                end else begin
                    n_drain = r_drain + aabb_rq_pkg::DRAIN_W'(1);
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_scan   <= '0;
            r_drain  <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_mode   <= aabb_rq_pkg::MODE_NONE;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_drain <= n_drain;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_mode  <= n_mode;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rd_addr   = r_scan[AW-1:0];
    assign o_emit_k    = r_k;

endmodule

// ----- rtl/core/aabb_region_overlap_query.sv -----
// Region table with box overlap query. A load request leaves the input free.
// A query scans the first scan-count entries of the table through one RAM read
// port, waits for the distance pipeline to drain, then gives one result per
// cycle while the output is not stalled. Up to MAX_MATCHES results per query.
// Synchronous active-low reset clears valid flags, the scan-count register and
// all control state; the table contents need no clearing.
module aabb_region_overlap_query #(
    parameter int TABLE_DEPTH = aabb_rq_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_MATCHES = aabb_rq_pkg::MAX_MATCHES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  aabb_rq_pkg::t_in              i_in,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output aabb_rq_pkg::t_out             o_out,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_valid,
    input  logic [aabb_rq_pkg::CFG_W-1:0] i_cfg_data,
    output logic                          o_cfg_ready
);

    localparam int AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int KW = $clog2(MAX_MATCHES + 1);

    aabb_rq_pkg::t_dp_cmd  cmd;
    aabb_rq_pkg::t_dp_stat stat;
    logic [AW-1:0]         rd_addr;
    logic [KW-1:0]         emit_k, cnt3, cntxz;

    aabb_rq_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .i_cnt3      (cnt3),
        .i_cntxz     (cntxz),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_emit_k    (emit_k)
    );

    aabb_rq_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_emit_k    (emit_k),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_cnt3      (cnt3),
        .o_cntxz     (cntxz),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.found |-> o_out.last_of_answer)
        else $error("empty answer not marked last");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.found |-> (o_out.region_number == '0))
        else $error("empty answer carries a region number");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.cmd == aabb_rq_pkg::CMD_QUERY) |=> o_in_stall)
        else $error("query request did not block the input");

    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result written over a held result");

endmodule
